/* src/pett_pkg.sv */
package pett_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int FIRE_W      = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  localparam int REQ_W    = 3;
  localparam int NOW_W    = 32;
  localparam int KEY_W    = 16;
  localparam int IVL_W    = 24;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int TIME_W   = 33;
  localparam int COUNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_PERIODIC = 3'd0,
    REQ_ADD_ONCE     = 3'd1,
    REQ_DELETE       = 3'd2,
    REQ_RUN          = 3'd3,
    REQ_QUERY        = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_FIRED     = 3'd3,
    ST_NONE_DUE  = 3'd4,
    ST_NEXT_TIME = 3'd5,
    ST_NO_TIMERS = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_EXEC,
    FSM_FINAL
  } fsm_t;

  // Write request into the slot store, applied at the scan index.
  typedef struct packed {
    logic              due_we;
    logic              slot_we;
    logic [TIME_W-1:0] due;
    logic [IVL_W-1:0]  per;
    logic [KEY_W-1:0]  own;
  } store_wr_t;

endpackage

/* src/periodic_event_timer_table.sv */
// Timer slot table: add, delete, run due timers, query earliest due time.
// Each request walks the slots one at a time, a store read and then an execute step
// per slot. Add and delete stop at the first hit; a run makes a due-check pass and,
// if any slot is due, a firing pass; a query with a known cache answers from the
// cache without a scan. The execute step waits while the sink stalls.
// Reset clears control, active marks, count and cache; slot data is unset.
module periodic_event_timer_table (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // now_time[31:0], owner_key[47:32], interval[71:48]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // slot[3:0], fired_key[19:4], time_value[52:20],
                                 // active_count[57:53], zero fill above
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast    // final result of the request
);

  localparam int SLOTS = pett_pkg::TABLE_SLOTS;
  localparam int IW    = pett_pkg::IDX_W;
  localparam int CW    = pett_pkg::CNT_W;
  localparam int FW    = pett_pkg::FIRE_W;
  localparam int TW    = pett_pkg::TIME_W;

  pett_pkg::fsm_t state, state_next;

  // captured request
  pett_pkg::req_t               req, req_next;
  logic [pett_pkg::NOW_W-1:0]   now_t, now_t_next;
  logic [pett_pkg::KEY_W-1:0]   key_t, key_t_next;
  logic [pett_pkg::IVL_W-1:0]   ivl_t, ivl_t_next;
  logic [TW-1:0]                add_due, add_due_next;

  // scan control
  logic [IW-1:0]    idx, idx_next;
  logic             pass2, pass2_next;
  logic [SLOTS-1:0] due_mask, due_mask_next;
  logic [FW-1:0]    fired, fired_next;

  // table state
  logic [SLOTS-1:0] active, active_next;
  logic [CW-1:0]    live, live_next;
  logic [TW-1:0]    e_due, e_due_next;
  logic             e_known, e_known_next;

  // output register
  logic                             out_valid, out_valid_next;
  pett_pkg::status_t                out_status, out_status_next;
  logic [pett_pkg::SLOT_W-1:0]      out_slot, out_slot_next;
  logic [pett_pkg::KEY_W-1:0]       out_key, out_key_next;
  logic [TW-1:0]                    out_time, out_time_next;
  logic [pett_pkg::COUNT_W-1:0]     out_count, out_count_next;
  logic                             out_last, out_last_next;

  // store interface
  pett_pkg::store_wr_t              wr;
  logic [TW-1:0]                    rd_due;
  logic [pett_pkg::IVL_W-1:0]       rd_per;
  logic [pett_pkg::KEY_W-1:0]       rd_own;

  // emit request from the sequencer
  logic                             emit;
  pett_pkg::status_t                e_status;
  logic [pett_pkg::SLOT_W-1:0]      e_slot;
  logic [pett_pkg::KEY_W-1:0]       e_key;
  logic [TW-1:0]                    e_time;
  logic                             e_last;

  logic             out_free;
  logic             last_idx;
  logic [TW-1:0]    now_ext;
  logic [SLOTS-1:0] rest_mask;

  pett_store u_store (
    .clk    (clk),
    .idx    (idx),
    .wr     (wr),
    .rd_due (rd_due),
    .rd_per (rd_per),
    .rd_own (rd_own)
  );

  // the output register frees up as soon as its transaction completes
  assign out_free = !out_valid || m_tready;
  assign last_idx = (idx == IW'(SLOTS - 1));
  assign now_ext  = {1'b0, now_t};
  assign s_tready = (state == pett_pkg::FSM_IDLE);

  always_comb begin
    state_next     = state;
    req_next       = req;
    now_t_next     = now_t;
    key_t_next     = key_t;
    ivl_t_next     = ivl_t;
    add_due_next   = add_due;
    idx_next       = idx;
    pass2_next     = pass2;
    due_mask_next  = due_mask;
    fired_next     = fired;
    active_next    = active;
    live_next      = live;
    e_due_next     = e_due;
    e_known_next   = e_known;
    wr             = '0;
    emit           = 1'b0;
    e_status       = pett_pkg::ST_ADDED;
    e_slot         = '0;
    e_key          = '0;
    e_time         = '0;
    e_last         = 1'b1;
    rest_mask      = due_mask;
    rest_mask[idx] = 1'b0;

    unique case (state)
      pett_pkg::FSM_IDLE: begin
        if (s_tvalid) begin
          req_next      = pett_pkg::req_t'(s_tuser);
          now_t_next    = s_tdata[31:0];
          key_t_next    = s_tdata[47:32];
          ivl_t_next    = s_tdata[71:48];
          add_due_next  = {1'b0, s_tdata[31:0]} + {9'b0, s_tdata[71:48]};
          idx_next      = '0;
          pass2_next    = 1'b0;
          due_mask_next = '0;
          fired_next    = '0;
          unique case (pett_pkg::req_t'(s_tuser))
            pett_pkg::REQ_ADD_PERIODIC, pett_pkg::REQ_ADD_ONCE,
            pett_pkg::REQ_DELETE, pett_pkg::REQ_RUN: begin
              state_next = pett_pkg::FSM_READ;
            end
            pett_pkg::REQ_QUERY: begin
              state_next = e_known ? pett_pkg::FSM_FINAL : pett_pkg::FSM_READ;
            end
            default: begin
              // unknown request: drop it, no result
              state_next = pett_pkg::FSM_IDLE;
            end
          endcase
        end
      end

      pett_pkg::FSM_READ: begin
        state_next = pett_pkg::FSM_EXEC;
      end

      pett_pkg::FSM_EXEC: begin
        if (out_free) begin
          unique case (req)
            pett_pkg::REQ_ADD_PERIODIC, pett_pkg::REQ_ADD_ONCE: begin
              if (!active[idx]) begin
                // take the lowest free slot
                wr.due_we        = 1'b1;
                wr.slot_we       = 1'b1;
                wr.due           = add_due;
                wr.per           = (req == pett_pkg::REQ_ADD_PERIODIC) ? ivl_t : '0;
                wr.own           = key_t;
                active_next[idx] = 1'b1;
                live_next        = live + CW'(1);
                if (!e_known || (add_due < e_due)) begin
                  e_due_next   = add_due;
                  e_known_next = 1'b1;
                end
                emit       = 1'b1;
                e_status   = pett_pkg::ST_ADDED;
                e_slot     = pett_pkg::SLOT_W'(idx);
                state_next = pett_pkg::FSM_IDLE;
              end else if (last_idx) begin
                emit       = 1'b1;
                e_status   = pett_pkg::ST_FULL;
                state_next = pett_pkg::FSM_IDLE;
              end else begin
                idx_next   = idx + IW'(1);
                state_next = pett_pkg::FSM_READ;
              end
            end

            pett_pkg::REQ_DELETE: begin
              if (active[idx] && (rd_own == key_t)) begin
                active_next[idx] = 1'b0;
                live_next        = live - CW'(1);
                emit             = 1'b1;
                e_status         = pett_pkg::ST_DELETED;
                state_next       = pett_pkg::FSM_IDLE;
              end else if (last_idx) begin
                emit       = 1'b1;
                e_status   = pett_pkg::ST_DELETED;
                state_next = pett_pkg::FSM_IDLE;
              end else begin
                idx_next   = idx + IW'(1);
                state_next = pett_pkg::FSM_READ;
              end
            end

            pett_pkg::REQ_RUN: begin
              if (!pass2) begin
                // first pass: mark due slots against the time of the request
                due_mask_next[idx] = active[idx] && (rd_due <= now_ext);
                if (last_idx) begin
                  if (due_mask_next == '0) begin
                    emit       = 1'b1;
                    e_status   = pett_pkg::ST_NONE_DUE;
                    state_next = pett_pkg::FSM_IDLE;
                  end else begin
                    idx_next   = '0;
                    pass2_next = 1'b1;
                    state_next = pett_pkg::FSM_READ;
                  end
                end else begin
                  idx_next   = idx + IW'(1);
                  state_next = pett_pkg::FSM_READ;
                end
              end else if (due_mask[idx]) begin
                // second pass: fire, then re-arm or free
                due_mask_next = rest_mask;
                e_known_next  = 1'b0;
                if (rd_per != '0) begin
                  wr.due_we = 1'b1;
                  wr.due    = now_ext + {9'b0, rd_per};
                end else begin
                  active_next[idx] = 1'b0;
                  live_next        = live - CW'(1);
                end
                emit       = 1'b1;
                e_status   = pett_pkg::ST_FIRED;
                e_slot     = pett_pkg::SLOT_W'(idx);
                e_key      = rd_own;
                e_last     = (rest_mask == '0) || (fired == FW'(pett_pkg::MAX_RESULTS - 1));
                fired_next = fired + FW'(1);
                if (e_last) begin
                  state_next = pett_pkg::FSM_IDLE;
                end else begin
                  idx_next   = idx + IW'(1);
                  state_next = pett_pkg::FSM_READ;
                end
              end else begin
                idx_next   = idx + IW'(1);
                state_next = pett_pkg::FSM_READ;
              end
            end

            pett_pkg::REQ_QUERY: begin
              // rebuild the cached minimum one slot at a time
              if (active[idx] && (!e_known || (rd_due < e_due))) begin
                e_due_next   = rd_due;
                e_known_next = 1'b1;
              end
              if (last_idx) begin
                emit       = 1'b1;
                e_status   = e_known_next ? pett_pkg::ST_NEXT_TIME
                                          : pett_pkg::ST_NO_TIMERS;
                e_time     = e_known_next ? e_due_next : '0;
                state_next = pett_pkg::FSM_IDLE;
              end else begin
                idx_next   = idx + IW'(1);
                state_next = pett_pkg::FSM_READ;
              end
            end

            default: begin
              state_next = pett_pkg::FSM_IDLE;
            end
          endcase
        end
      end

      pett_pkg::FSM_FINAL: begin
        // cache already holds the answer
        if (out_free) begin
          emit       = 1'b1;
          e_status   = pett_pkg::ST_NEXT_TIME;
          e_time     = e_due;
          state_next = pett_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_next = pett_pkg::FSM_IDLE;
      end
    endcase

    // load the output register; hold it while the sink stalls
    out_valid_next  = out_valid && !m_tready;
    out_status_next = out_status;
    out_slot_next   = out_slot;
    out_key_next    = out_key;
    out_time_next   = out_time;
    out_count_next  = out_count;
    out_last_next   = out_last;
    if (emit) begin
      out_valid_next  = 1'b1;
      out_status_next = e_status;
      out_slot_next   = e_slot;
      out_key_next    = e_key;
      out_time_next   = e_time;
      out_count_next  = pett_pkg::COUNT_W'(live_next);
      out_last_next   = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pett_pkg::FSM_IDLE;
      active    <= '0;
      live      <= '0;
      e_due     <= '0;
      e_known   <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      pass2     <= 1'b0;
      due_mask  <= '0;
      fired     <= '0;
    end else begin
      state     <= state_next;
      active    <= active_next;
      live      <= live_next;
      e_due     <= e_due_next;
      e_known   <= e_known_next;
      out_valid <= out_valid_next;
      idx       <= idx_next;
      pass2     <= pass2_next;
      due_mask  <= due_mask_next;
      fired     <= fired_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    now_t      <= now_t_next;
    key_t      <= key_t_next;
    ivl_t      <= ivl_t_next;
    add_due    <= add_due_next;
    out_status <= out_status_next;
    out_slot   <= out_slot_next;
    out_key    <= out_key_next;
    out_time   <= out_time_next;
    out_count  <= out_count_next;
    out_last   <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'b0, out_count, out_time, out_key, out_slot};

endmodule

/* src/pett_store.sv */
module pett_store (
  input  logic                             clk,
  input  logic [pett_pkg::IDX_W-1:0]       idx,
  input  pett_pkg::store_wr_t              wr,
  output logic [pett_pkg::TIME_W-1:0]      rd_due,
  output logic [pett_pkg::IVL_W-1:0]       rd_per,
  output logic [pett_pkg::KEY_W-1:0]       rd_own
);

  logic [pett_pkg::TIME_W-1:0] due_mem [pett_pkg::TABLE_SLOTS];
  logic [pett_pkg::IVL_W-1:0]  per_mem [pett_pkg::TABLE_SLOTS];
  logic [pett_pkg::KEY_W-1:0]  own_mem [pett_pkg::TABLE_SLOTS];

  // one shared address: write and registered read both at the scan index
  always_ff @(posedge clk) begin
    if (wr.due_we) begin
      due_mem[idx] <= wr.due;
    end
    if (wr.slot_we) begin
      per_mem[idx] <= wr.per;
      own_mem[idx] <= wr.own;
    end
    rd_due <= due_mem[idx];
    rd_per <= per_mem[idx];
    rd_own <= own_mem[idx];
  end

endmodule

/* verif/timer_table_checker.sv */
module timer_table_checker
  import pett_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,   // now_time[31:0], owner_key[47:32], interval[71:48]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // slot[3:0], fired_key[19:4], time_value[52:20],
                                 // active_count[57:53], zero fill above
  input  logic [2:0]  m_tuser,   // status[2:0]
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   when;
    logic [COUNT_W-1:0]  live;
    logic                last;
  } timer_result_t;

  // Shadow copy of the timer table.
  logic [TIME_W-1:0]  slot_due    [TABLE_SLOTS];
  logic [IVL_W-1:0]   slot_period [TABLE_SLOTS];
  logic [KEY_W-1:0]   slot_key    [TABLE_SLOTS];
  logic               slot_live   [TABLE_SLOTS];
  logic [TIME_W-1:0]  next_due;
  logic               next_known;
  logic [COUNT_W-1:0] live_total;

  timer_result_t results_due[$];
  int            result_idx;

  initial begin
    errors     = 0;
    pending    = 0;
    result_idx = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
             result_idx, what, got, want);
    errors++;
  endtask

  function automatic timer_result_t make_result(input status_t st, input int idx,
                                                input logic [KEY_W-1:0] key,
                                                input logic [TIME_W-1:0] when,
                                                input logic last);
    timer_result_t r;
    r.status = st;
    r.slot   = SLOT_W'(idx);
    r.key    = key;
    r.when   = when;
    r.live   = live_total;
    r.last   = last;
    return r;
  endfunction

  // Update the shadow table for one request and queue the results it causes.
  task automatic apply_request(input logic [REQ_W-1:0] kind,
                               input logic [NOW_W-1:0] now,
                               input logic [KEY_W-1:0] key,
                               input logic [IVL_W-1:0] ivl);
    logic [TIME_W-1:0] due;
    timer_result_t     prev;
    bit                have_prev;
    bit                done;
    int                hits;
    done      = 1'b0;
    have_prev = 1'b0;
    hits      = 0;
    case (kind)
      REQ_ADD_PERIODIC, REQ_ADD_ONCE: begin
        due = {1'b0, now} + {{(TIME_W-IVL_W){1'b0}}, ivl};
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!done && !slot_live[i]) begin
            done           = 1'b1;
            slot_due[i]    = due;
            slot_period[i] = (kind == REQ_ADD_PERIODIC) ? ivl : '0;
            slot_key[i]    = key;
            slot_live[i]   = 1'b1;
            if (!next_known || due < next_due) begin
              next_due   = due;
              next_known = 1'b1;
            end
            live_total++;
            results_due.push_back(make_result(ST_ADDED, i, '0, '0, 1'b1));
          end
        end
        if (!done)
          results_due.push_back(make_result(ST_FULL, 0, '0, '0, 1'b1));
      end
      REQ_DELETE: begin
        // the cached earliest time is left alone on purpose
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!done && slot_live[i] && slot_key[i] == key) begin
            done         = 1'b1;
            slot_live[i] = 1'b0;
            live_total--;
          end
        end
        results_due.push_back(make_result(ST_DELETED, 0, '0, '0, 1'b1));
      end
      REQ_RUN: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (hits < MAX_RESULTS && slot_live[i] && slot_due[i] <= {1'b0, now}) begin
            next_known = 1'b0;
            if (slot_period[i] != '0) begin
              slot_due[i] = {1'b0, now} + {{(TIME_W-IVL_W){1'b0}}, slot_period[i]};
            end else begin
              slot_live[i] = 1'b0;
              live_total--;
            end
            if (have_prev)
              results_due.push_back(prev);
            prev      = make_result(ST_FIRED, i, slot_key[i], '0, 1'b0);
            have_prev = 1'b1;
            hits++;
          end
        end
        if (have_prev) begin
          prev.last = 1'b1;
          results_due.push_back(prev);
        end else begin
          results_due.push_back(make_result(ST_NONE_DUE, 0, '0, '0, 1'b1));
        end
      end
      REQ_QUERY: begin
        if (!next_known) begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_live[i] && (!next_known || slot_due[i] < next_due)) begin
              next_due   = slot_due[i];
              next_known = 1'b1;
            end
          end
        end
        if (next_known)
          results_due.push_back(make_result(ST_NEXT_TIME, 0, '0, next_due, 1'b1));
        else
          results_due.push_back(make_result(ST_NO_TIMERS, 0, '0, '0, 1'b1));
      end
      default: ;  // unknown request: ignored by the block
    endcase
  endtask

  always @(posedge clk) begin : watch
    timer_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_due[i]    = '0;
        slot_period[i] = '0;
        slot_key[i]    = '0;
        slot_live[i]   = 1'b0;
      end
      next_due   = '0;
      next_known = 1'b0;
      live_total = '0;
      results_due.delete();
    end else begin
      // results first: a request taken on this edge cannot answer on it
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", {m_tuser, m_tdata[57:0]}, '0);
        end else begin
          want = results_due.pop_front();
          if (m_tuser !== want.status)
            report_mismatch("status", m_tuser, want.status);
          if (m_tdata[3:0] !== want.slot)
            report_mismatch("slot", m_tdata[3:0], want.slot);
          if (m_tdata[19:4] !== want.key)
            report_mismatch("fired_key", m_tdata[19:4], want.key);
          if (m_tdata[52:20] !== want.when)
            report_mismatch("time_value", m_tdata[52:20], want.when);
          if (m_tdata[57:53] !== want.live)
            report_mismatch("active_count", m_tdata[57:53], want.live);
          if (m_tdata[63:58] !== '0)
            report_mismatch("zero fill", m_tdata[63:58], '0);
          if (m_tlast !== want.last)
            report_mismatch("tlast", m_tlast, want.last);
        end
        result_idx++;
      end
      if (s_tvalid && s_tready)
        apply_request(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[71:48]);
    end
    pending = results_due.size();
  end

endmodule

/* verif/tb.sv */
module tb;
  import pett_pkg::*;

  // request codes the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam int ITEM_TARGET  = 410;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 150;
  localparam int PAUSE_AT     = 260;
  localparam int DRAIN_CYCLES = 80;   // a bit above the worst-case request latency

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;   // now_time[31:0], owner_key[47:32], interval[71:48]
  logic [2:0]  s_tuser  = '0;   // req_type[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // slot[3:0], fired_key[19:4], time_value[52:20],
                                // active_count[57:53], zero fill above
  logic [2:0]  m_tuser;         // status[2:0]
  logic        m_tlast;

  int          errors;
  int          pending;
  int          req_count = 0;
  bit          steady    = 1'b0;   // no gaps on either side while set
  bit          hold_req  = 1'b0;   // ask the receiver for one long hold-off
  logic [15:0] key_pool [8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  periodic_event_timer_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  timer_table_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  // Mostly short gaps, now and then a long one; none in steady stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Keys mostly come from a small pool so deletes find their timers.
  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 7)];
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Short delays keep periodic timers firing; the odd wide one covers the field.
  function automatic logic [23:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 24'($urandom_range(1, 40));
    if (r < 85) return '0;
    if (r < 95) return 24'($urandom_range(41, 1000));
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // Offer one request, hold it until the block takes it, then idle a while.
  task automatic issue_request(input logic [REQ_W-1:0] kind, input logic [31:0] now,
                               input logic [15:0] key, input logic [23:0] ivl);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {ivl, key, now};
    do @(posedge clk); while (!s_tready);
    if (kind < REQ_UNUSED_LO) req_count++;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : result_sink
    int stall;
    int r;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if (steady) begin
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          if (r < 90)      stall = $urandom_range(0, 2);
          else if (r < 98) stall = $urandom_range(3, 10);
          else             stall = $urandom_range(15, 40);
        end
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned now_base;
    int          seq;
    int          n;
    bit          first;
    bit          held;
    bit          paused;
    logic [REQ_W-1:0] kind;

    first  = 1'b1;
    held   = 1'b0;
    paused = 1'b0;
    for (int i = 0; i < 8; i++) key_pool[i] = 16'($urandom_range(1, 16'hFFFE));
    key_pool[6] = 16'h0000;
    key_pool[7] = 16'hFFFF;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, ignored codes, widest fields, cache corner cases.
    issue_request(REQ_QUERY, 32'd0, 16'd0, 24'd0);                  // no timers
    issue_request(REQ_RUN, 32'd0, 16'd0, 24'd0);                    // none due
    issue_request(REQ_DELETE, 32'd0, 16'h1234, 24'd0);              // absent key
    issue_request(REQ_UNUSED_HI, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
    issue_request(REQ_UNUSED_LO, 32'h5555_AAAA, 16'hA5A5, 24'h5A_5A5A);
    issue_request(REQ_ADD_PERIODIC, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF);  // carry
    issue_request(REQ_ADD_ONCE, 32'd0, 16'h0000, 24'd0);
    issue_request(REQ_ADD_PERIODIC, 32'd5, 16'h0001, 24'd0);        // zero period
    issue_request(REQ_QUERY, 32'd0, 16'd0, 24'd0);
    issue_request(REQ_DELETE, 32'd0, 16'hFFFF, 24'd0);
    issue_request(REQ_QUERY, 32'd0, 16'd0, 24'd0);                  // cache kept after a delete
    issue_request(REQ_RUN, 32'd5, 16'd0, 24'd0);                    // two fire
    issue_request(REQ_QUERY, 32'd0, 16'd0, 24'd0);                  // rescan, empty
    issue_request(REQ_ADD_PERIODIC, 32'd10, key_pool[0], 24'd3);
    issue_request(REQ_RUN, 32'd13, 16'd0, 24'd0);                   // fire and re-arm
    issue_request(REQ_RUN, 32'd12, 16'd0, 24'd0);                   // not yet due
    issue_request(REQ_QUERY, 32'd0, 16'd0, 24'd0);
    issue_request(REQ_ADD_ONCE, 32'hFFFF_FFF0, 16'hA5A5, 24'd100);  // due past 32 bits
    issue_request(REQ_RUN, 32'hFFFF_FFFF, 16'd0, 24'd0);            // too late to fire
    issue_request(REQ_DELETE, 32'd0, 16'hA5A5, 24'd0);

    // Random: sequences built around a moving clock.
    now_base = 1000;
    while (req_count < ITEM_TARGET) begin
      seq   = first ? 0 : $urandom_range(0, 99);
      first = 1'b0;

      if (!held && req_count >= HOLD_AT) begin
        // stall the receiver long enough to back the block up
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && req_count >= PAUSE_AT) begin
        paused = 1'b1;
        wait_results_drained();
      end

      if (seq < 25) begin
        // fill burst of adds; the first one runs the table up to full and past it, then sweeps
        n = (seq == 0) ? 17 : $urandom_range(4, 18);
        repeat (n) begin
          kind = ($urandom_range(0, 1) == 0) ? REQ_ADD_PERIODIC : REQ_ADD_ONCE;
          issue_request(kind, now_base, pick_key(), pick_interval());
        end
        if (seq == 0) begin
          now_base += 5000;
          issue_request(REQ_RUN, now_base, 16'd0, 24'd0);
        end
      end else if (seq < 55) begin
        // advance time and fire whatever is due
        repeat ($urandom_range(2, 6)) begin
          now_base += $urandom_range(0, 40);
          issue_request(REQ_RUN, now_base, pick_key(), 24'd0);
          if ($urandom_range(0, 99) < 40)
            issue_request(REQ_QUERY, now_base, 16'd0, 24'd0);
        end
      end else if (seq < 70) begin
        // deletes, sometimes the whole pool, then look at the cache
        if ($urandom_range(0, 3) == 0) begin
          for (int i = 0; i < 8; i++)
            issue_request(REQ_DELETE, now_base, key_pool[i], pick_interval());
        end else begin
          repeat ($urandom_range(1, 4))
            issue_request(REQ_DELETE, now_base, pick_key(), 24'd0);
        end
        issue_request(REQ_QUERY, now_base, 16'd0, 24'd0);
      end else if (seq < 80) begin
        // adds interleaved with queries
        repeat ($urandom_range(2, 5)) begin
          kind = ($urandom_range(0, 1) == 0) ? REQ_ADD_PERIODIC : REQ_ADD_ONCE;
          issue_request(kind, now_base, pick_key(), pick_interval());
          issue_request(REQ_QUERY, now_base, 16'd0, 24'd0);
        end
      end else if (seq < 90) begin
        // noise: any code, any field value
        repeat ($urandom_range(1, 4)) begin
          kind = REQ_W'($urandom_range(0, 7));
          issue_request(kind, $urandom(), pick_key(), 24'($urandom_range(0, 24'hFFFFFF)));
        end
      end else if (seq < 95) begin
        // jump the clock; now and then flush at the top of the range
        now_base = $urandom();
        if ($urandom_range(0, 2) == 0)
          issue_request(REQ_RUN, 32'hFFFF_FFFF, 16'd0, 24'd0);
        issue_request(REQ_RUN, now_base, 16'd0, 24'd0);
      end else begin
        steady = !steady;
      end
    end
    steady = 1'b0;

    // Let everything drain, then give the block its latency once more.
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
src/pett_pkg.sv
src/pett_store.sv
src/periodic_event_timer_table.sv
verif/timer_table_checker.sv
verif/tb.sv
